// ===== rtl/core/mrsf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsf_pkg
// Constants, control word layout and microcode table for the Morton range
// split finder.
// ----------------------------------------------------------------------------
package mrsf_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int CODE_BITS   = 30;
   localparam int IDX_BITS    = 10;
   localparam int SPLIT_BITS  = IDX_BITS + 1;

   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   // Request op codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Table read address source
   typedef enum logic [1:0] {
      RD_NONE,
      RD_LEFT,
      RD_RIGHT,
      RD_PROBE
   } rd_sel_type;

   // Datapath action for one step
   typedef enum logic [2:0] {
      ACT_ACCEPT,
      ACT_NONE,
      ACT_LD_FIRST,
      ACT_SETUP,
      ACT_ITER,
      ACT_EMIT_SPLIT,
      ACT_EMIT_MID,
      ACT_EMIT_ERR
   } act_type;

   // Jump condition
   typedef enum logic [2:0] {
      C_NEVER,
      C_NO_QUERY,
      C_REVERSED,
      C_EQUAL,
      C_MORE,
      C_BUSY
   } cond_type;

   typedef logic [2:0] step_type;

   // Microcode step addresses
   localparam step_type P_WAIT       = 3'd0;
   localparam step_type P_CHECK      = 3'd1;
   localparam step_type P_FIRST      = 3'd2;
   localparam step_type P_SETUP      = 3'd3;
   localparam step_type P_LOOP       = 3'd4;
   localparam step_type P_EMIT_SPLIT = 3'd5;
   localparam step_type P_EMIT_ERR   = 3'd6;
   localparam step_type P_EMIT_MID   = 3'd7;

   typedef struct packed {
      rd_sel_type rd_sel;
      act_type    act;
      cond_type   cond;
      step_type   jump;   // taken when cond holds
      step_type   next;   // taken otherwise
   } ucode_type;

   // Control program
   function automatic ucode_type ucode_rom(input step_type pc);
      ucode_type cw;
      unique case (pc)
         P_WAIT:       cw = '{RD_NONE,  ACT_ACCEPT,     C_NO_QUERY, P_WAIT,       P_CHECK};
         P_CHECK:      cw = '{RD_LEFT,  ACT_NONE,       C_REVERSED, P_EMIT_ERR,   P_FIRST};
         P_FIRST:      cw = '{RD_RIGHT, ACT_LD_FIRST,   C_NEVER,    P_WAIT,       P_SETUP};
         P_SETUP:      cw = '{RD_NONE,  ACT_SETUP,      C_EQUAL,    P_EMIT_MID,   P_LOOP};
         P_LOOP:       cw = '{RD_PROBE, ACT_ITER,       C_MORE,     P_LOOP,       P_EMIT_SPLIT};
         P_EMIT_SPLIT: cw = '{RD_NONE,  ACT_EMIT_SPLIT, C_BUSY,     P_EMIT_SPLIT, P_WAIT};
         P_EMIT_ERR:   cw = '{RD_NONE,  ACT_EMIT_ERR,   C_BUSY,     P_EMIT_ERR,   P_WAIT};
         P_EMIT_MID:   cw = '{RD_NONE,  ACT_EMIT_MID,   C_BUSY,     P_EMIT_MID,   P_WAIT};
         default:      cw = '{RD_NONE,  ACT_ACCEPT,     C_NO_QUERY, P_WAIT,       P_CHECK};
      endcase
      return cw;
   endfunction

   // Mask of all bits at and above the highest set bit of x. A code whose
   // XOR with the first code is clear under this mask shares a longer prefix.
   function automatic code_type prefix_mask(input code_type x);
      code_type s;
      s = x;
      for (int sh = 1; sh < CODE_BITS; sh = sh * 2) begin
         s = s | (s >> sh);
      end
      return ~(s >> 1);
   endfunction

endpackage

// ===== rtl/core/morton_range_split_finder.sv =====
// ----------------------------------------------------------------------------
// morton_range_split_finder
// Sorted Morton code table with a split search for linear BVH construction.
// ----------------------------------------------------------------------------
// A write beat (op 0) stores one code and gives no response. A query beat
// (op 1) returns one response: an error for a reversed range, a midpoint
// split for equal end codes, and for any other range the split found in
// n = max(1, ceil(log2(right - left))) halving steps of the binary search.
// The search rate is set by one table read per step on the single read port
// of the code memory, as each probe address depends on the previous compare.
// A new beat is taken only in the wait step; a finished response may still
// sit in the output register while the next beat is taken.
module morton_range_split_finder
   import mrsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [IDX_BITS-1:0]   req_entry_index,
   input  logic [CODE_BITS-1:0]  req_code_value,
   input  logic [IDX_BITS-1:0]   req_left_index,
   input  logic [IDX_BITS-1:0]   req_right_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SPLIT_BITS-1:0] rsp_split_index,
   output logic                  rsp_range_error
);

   // Code memory
   code_type  mem [TABLE_DEPTH];
   code_type  rd_data_ff;
   idx_type   rd_addr;

   step_type  pc_ff, pc_in;
   ucode_type cw;

   idx_type   left_ff, left_in;
   idx_type   right_ff, right_in;
   code_type  first_ff, first_in;
   code_type  mask_ff, mask_in;
   idx_type   split_ff, split_in;
   idx_type   step_ff, step_in;
   idx_type   probe_ff, probe_in;
   logic      probe_ok_ff, probe_ok_in;
   logic      pending_ff, pending_in;
   logic      more_ff, more_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SPLIT_BITS-1:0] rsp_split_ff, rsp_split_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  accept;
   logic                  busy;
   logic                  cond_hit;
   logic                  hit;
   idx_type               split_upd;
   idx_type               step_nx;
   logic [SPLIT_BITS-1:0] step_inc;
   logic [SPLIT_BITS-1:0] probe_sum;
   logic [SPLIT_BITS-1:0] mid_sum;

   assign cw        = ucode_rom(pc_ff);
   assign busy      = rsp_valid_ff & rsp_stall;
   assign req_stall = (cw.act != ACT_ACCEPT);
   assign accept    = req_valid & ~req_stall;

   // One search step: fold in the last probe, then form the next one
   assign hit       = pending_ff & probe_ok_ff &
                      (((first_ff ^ rd_data_ff) & mask_ff) == '0);
   assign split_upd = hit ? probe_ff : split_ff;
   assign step_inc  = ({1'b0, step_ff} + SPLIT_BITS'(1)) >> 1;
   assign step_nx   = step_inc[IDX_BITS-1:0];
   assign probe_sum = {1'b0, split_upd} + {1'b0, step_nx};
   assign mid_sum   = {1'b0, left_ff} + {1'b0, right_ff};

   // Read address select
   always_comb begin
      unique case (cw.rd_sel)
         RD_LEFT:  rd_addr = left_ff;
         RD_RIGHT: rd_addr = right_ff;
         RD_PROBE: rd_addr = probe_sum[IDX_BITS-1:0];
         default:  rd_addr = left_ff;
      endcase
   end

   // Jump condition
   always_comb begin
      unique case (cw.cond)
         C_NEVER:    cond_hit = 1'b0;
         C_NO_QUERY: cond_hit = ~(accept & (req_op == OP_QUERY));
         C_REVERSED: cond_hit = (left_ff > right_ff);
         C_EQUAL:    cond_hit = (first_ff == rd_data_ff);
         C_MORE:     cond_hit = more_ff;
         C_BUSY:     cond_hit = busy;
         default:    cond_hit = 1'b0;
      endcase
   end

   assign pc_in = cond_hit ? cw.jump : cw.next;

   // Datapath actions
   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      first_in     = first_ff;
      mask_in      = mask_ff;
      split_in     = split_ff;
      step_in      = step_ff;
      probe_in     = probe_ff;
      probe_ok_in  = probe_ok_ff;
      pending_in   = pending_ff;
      more_in      = more_ff;
      rsp_valid_in = busy;
      rsp_split_in = rsp_split_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (cw.act)
         ACT_ACCEPT: begin
            if (accept && req_op == OP_QUERY) begin
               left_in  = req_left_index;
               right_in = req_right_index;
            end
         end
         ACT_LD_FIRST: begin
            first_in = rd_data_ff;
         end
         ACT_SETUP: begin
            mask_in    = prefix_mask(first_ff ^ rd_data_ff);
            split_in   = left_ff;
            step_in    = right_ff - left_ff;
            pending_in = 1'b0;
            more_in    = 1'b1;
         end
         ACT_ITER: begin
            split_in = split_upd;
            if (more_ff) begin
               step_in     = step_nx;
               probe_in    = probe_sum[IDX_BITS-1:0];
               probe_ok_in = (probe_sum < {1'b0, right_ff});
               pending_in  = 1'b1;
               more_in     = (step_nx > idx_type'(1));
            end else begin
               pending_in = 1'b0;
            end
         end
         ACT_EMIT_SPLIT: begin
            if (!busy) begin
               rsp_valid_in = 1'b1;
               rsp_split_in = {1'b0, split_ff} + SPLIT_BITS'(1);
               rsp_err_in   = 1'b0;
            end
         end
         ACT_EMIT_MID: begin
            if (!busy) begin
               rsp_valid_in = 1'b1;
               rsp_split_in = (mid_sum >> 1) + SPLIT_BITS'(1);
               rsp_err_in   = 1'b0;
            end
         end
         ACT_EMIT_ERR: begin
            if (!busy) begin
               rsp_valid_in = 1'b1;
               rsp_split_in = '0;
               rsp_err_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Memory: write on accepted write beats, registered read every cycle
   always_ff @(posedge clock) begin
      if (accept && req_op == OP_WRITE &&
          {1'b0, req_entry_index} < SPLIT_BITS'(TABLE_DEPTH)) begin
         mem[req_entry_index] <= req_code_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= P_WAIT;
         pending_ff   <= 1'b0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         pending_ff   <= pending_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff      <= left_in;
      right_ff     <= right_in;
      first_ff     <= first_in;
      mask_ff      <= mask_in;
      split_ff     <= split_in;
      step_ff      <= step_in;
      probe_ff     <= probe_in;
      probe_ok_ff  <= probe_ok_in;
      rsp_split_ff <= rsp_split_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_split_index = rsp_split_ff;
   assign rsp_range_error = rsp_err_ff;

   // An error response always carries a zero split
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_split_ff == '0)
      else $error("error response with nonzero split");

   // The search never moves the split to or past the right end
   a_split_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff == P_LOOP |-> split_ff < right_ff)
      else $error("split reached right end during search");

   // A finished search goes straight to the split response step
   a_loop_exit: assert property (@(posedge clock) disable iff (reset)
      pc_ff == P_LOOP && !more_ff |=> pc_ff == P_EMIT_SPLIT)
      else $error("search exit did not reach response step");

   // Beats are taken only in the wait step
   a_accept_wait: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> pc_ff == P_WAIT)
      else $error("beat taken outside wait step");

endmodule
